// File: sv/brusselator_1d_rate_stencil_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Brusselator rate stencil checker
// Each macro expands to one labeled concurrent assertion on clock.
// ----------------------------------------------------------------------------
`ifndef BRUSSELATOR_1D_RATE_STENCIL_ASSERT_SVH
`define BRUSSELATOR_1D_RATE_STENCIL_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define BRU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define BRU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after reset was sampled high.
`define BRU_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bru_pkg
// Shared types, constants and saturating fixed point helpers.
// ----------------------------------------------------------------------------
package bru_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int PRODUCT_WIDTH = 2 * VALUE_WIDTH;

   typedef logic signed [VALUE_WIDTH-1:0]   value_type;
   typedef logic signed [PRODUCT_WIDTH-1:0] product_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   // fixed point one, clamped when the fraction leaves no room for it
   localparam value_type UNIT_VALUE = (FRACTION_BITS >= VALUE_WIDTH - 1) ?
                                      VALUE_MAX : (value_type'(1) << FRACTION_BITS);

   // register map
   localparam int CSR_INDEX_WIDTH = 3;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_FEED_A      = csr_index_type'(0);
   localparam csr_index_type CSR_FEED_B      = csr_index_type'(1);
   localparam csr_index_type CSR_BOUNDARY_Y  = csr_index_type'(2);
   localparam csr_index_type CSR_DIFFUSION_X = csr_index_type'(3);
   localparam csr_index_type CSR_DIFFUSION_Y = csr_index_type'(4);

   typedef struct packed {
      value_type feed_a;
      value_type feed_b;
      value_type boundary_y;
      value_type diffusion_x;
      value_type diffusion_y;
   } cfg_type;

   // one stencil evaluation handed from front end to back end
   typedef struct packed {
      value_type left_x;
      value_type left_y;
      value_type center_x;
      value_type center_y;
      value_type right_x;
      value_type right_y;
      logic      line_end;
   } job_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      value_type rate_x;
      value_type rate_y;
      logic      line_end;
   } result_type;

   typedef enum logic {
      WIN_EMPTY,
      WIN_HOLDING
   } window_state_type;

   // job queue: power of two depth, room for two pushes per transaction
   localparam int JOBQ_DEPTH       = 4;
   localparam int JOBQ_PTR_WIDTH   = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_COUNT_WIDTH = $clog2(JOBQ_DEPTH + 1);

   // result queue: power of two depth
   localparam int OUTQ_DEPTH       = 16;
   localparam int OUTQ_PTR_WIDTH   = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_COUNT_WIDTH = $clog2(OUTQ_DEPTH + 1);

   function automatic value_type sat_add(value_type a, value_type b);
      logic [VALUE_WIDTH:0] sum;
      sum = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) begin
         sat_add = sum[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
      end else begin
         sat_add = sum[VALUE_WIDTH-1:0];
      end
   endfunction

   function automatic value_type sat_sub(value_type a, value_type b);
      logic [VALUE_WIDTH:0] diff;
      diff = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (diff[VALUE_WIDTH] != diff[VALUE_WIDTH-1]) begin
         sat_sub = diff[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
      end else begin
         sat_sub = diff[VALUE_WIDTH-1:0];
      end
   endfunction

   // exact signed product
   function automatic product_type mul_full(value_type a, value_type b);
      mul_full = product_type'(a) * product_type'(b);
   endfunction

   // drop the fraction (floor) and clamp to the value range
   function automatic value_type sat_prod(product_type p);
      logic [VALUE_WIDTH-FRACTION_BITS:0] upper;
      upper = p[PRODUCT_WIDTH-1:FRACTION_BITS+VALUE_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         sat_prod = p[FRACTION_BITS+VALUE_WIDTH-1:FRACTION_BITS];
      end else begin
         sat_prod = p[PRODUCT_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
      end
   endfunction

endpackage
`default_nettype wire

// File: sv/brusselator_1d_rate_stencil.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brusselator_1d_rate_stencil
// Streaming time derivative stencil for a 1-D two-species Brusselator mesh.
// ----------------------------------------------------------------------------
// Usage:
//  - Request side is a queue push: one mesh point (x, y, final flag) per
//    transaction, taken when req_push is high and req_full is low. Points
//    come in mesh order; the last point of a line has req_final_point set.
//  - Response side is a queue pop: the oldest rate pair sits on rsp_* while
//    rsp_empty is low and leaves on an edge with rsp_pop high.
//  - The first point of a line gives no result; every later point releases
//    the result of its left neighbor, and a final point also releases its
//    own, flagged with rsp_line_end. A one point line gives one result.
//  - Path: a result passes through the job queue, the back end pipeline
//    and the result queue after the transaction that completes its window;
//    the final point's own result issues after its neighbor's.
//  - Throughput: one point per cycle while req_full is low, set by the one
//    job per cycle back end issue; a final point costs one more slot.
//  - csr_* writes the five Q16.16 constants; write only while idle.
//  - Reset clears the registers to zero, empties the window and both queues.
//  - A stalled receiver keeps results in a 16 entry queue; the back end
//    stops issuing once all slots are spoken for, the 4 entry job queue
//    then fills and req_full rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module brusselator_1d_rate_stencil
   import bru_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // request queue
   input  logic          req_push,
   output logic          req_full,
   input  value_type     req_x_value,
   input  value_type     req_y_value,
   input  logic          req_final_point,
   // response queue
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output value_type     rsp_rate_x,
   output value_type     rsp_rate_y,
   output logic          rsp_line_end,
   // register writes
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  value_type     csr_wdata
);

   cfg_type  cfg;
   push_type push;
   job_type  job_first, job_second, job_head;
   logic     jobq_room, job_valid, job_pop;

   // constants used by both halves
   bru_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // front end: window and line bookkeeping, up to two jobs per transaction
   bru_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .req_final_point (req_final_point),
      .jobq_room       (jobq_room),
      .push            (push),
      .job_first       (job_first),
      .job_second      (job_second)
   );

   // decouples the two halves; room means two free slots
   bru_job_queue u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .job_first  (job_first),
      .job_second (job_second),
      .pop        (job_pop),
      .head       (job_head),
      .head_valid (job_valid),
      .room       (jobq_room)
   );

   // back end: arithmetic pipeline and result queue
   bru_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .job          (job_head),
      .job_valid    (job_valid),
      .job_pop      (job_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_rate_x   (rsp_rate_x),
      .rsp_rate_y   (rsp_rate_y),
      .rsp_line_end (rsp_line_end)
   );

endmodule
`default_nettype wire

// File: sv/bru_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bru_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bru_csr
   import bru_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  value_type     csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FEED_A:      cfg_in.feed_a      = csr_wdata;
            CSR_FEED_B:      cfg_in.feed_b      = csr_wdata;
            CSR_BOUNDARY_Y:  cfg_in.boundary_y  = csr_wdata;
            CSR_DIFFUSION_X: cfg_in.diffusion_x = csr_wdata;
            CSR_DIFFUSION_Y: cfg_in.diffusion_y = csr_wdata;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: sv/bru_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bru_front
// Accepts mesh points, keeps the three point window, emits stencil jobs.
// ----------------------------------------------------------------------------
module bru_front
   import bru_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      req_push,
   output logic      req_full,
   input  value_type req_x_value,
   input  value_type req_y_value,
   input  logic      req_final_point,
   input  logic      jobq_room,
   output push_type  push,
   output job_type   job_first,
   output job_type   job_second
);

   window_state_type state_ff;
   window_state_type state_in;
   value_type        prev_x_ff, prev_y_ff, center_x_ff, center_y_ff;
   value_type        prev_x_in, prev_y_in, center_x_in, center_y_in;
   logic             accept;

   assign accept   = req_push && jobq_room;
   assign req_full = !jobq_room;

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         unique case (state_ff)
            WIN_EMPTY:   state_in = req_final_point ? WIN_EMPTY : WIN_HOLDING;
            WIN_HOLDING: state_in = req_final_point ? WIN_EMPTY : WIN_HOLDING;
            default:     state_in = WIN_EMPTY;
         endcase
      end
   end

   // outputs and window update
   always_comb begin
      push        = '0;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      job_first   = '{left_x: prev_x_ff, left_y: prev_y_ff,
                      center_x: center_x_ff, center_y: center_y_ff,
                      right_x: req_x_value, right_y: req_y_value, line_end: 1'b0};
      job_second  = '{left_x: center_x_ff, left_y: center_y_ff,
                      center_x: req_x_value, center_y: req_y_value,
                      right_x: cfg.feed_a, right_y: cfg.boundary_y, line_end: 1'b1};
      if (accept) begin
         unique case (state_ff)
            WIN_EMPTY: begin
               if (req_final_point) begin
                  // single point line: boundary on both sides
                  job_first  = '{left_x: cfg.feed_a, left_y: cfg.boundary_y,
                                 center_x: req_x_value, center_y: req_y_value,
                                 right_x: cfg.feed_a, right_y: cfg.boundary_y,
                                 line_end: 1'b1};
                  push.first = 1'b1;
               end else begin
                  prev_x_in   = cfg.feed_a;
                  prev_y_in   = cfg.boundary_y;
                  center_x_in = req_x_value;
                  center_y_in = req_y_value;
               end
            end
            WIN_HOLDING: begin
               push.first  = 1'b1;
               push.second = req_final_point;
               prev_x_in   = center_x_ff;
               prev_y_in   = center_y_ff;
               center_x_in = req_x_value;
               center_y_in = req_y_value;
            end
            default: push = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WIN_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      center_x_ff <= center_x_in;
      center_y_ff <= center_y_in;
   end

endmodule
`default_nettype wire

// File: sv/bru_job_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bru_job_queue
// Short job queue between front and back end; takes up to two jobs a cycle.
// ----------------------------------------------------------------------------
module bru_job_queue
   import bru_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  job_type  job_first,
   input  job_type  job_second,
   input  logic     pop,
   output job_type  head,
   output logic     head_valid,
   output logic     room
);

   job_type                     entry_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_next;
   logic [JOBQ_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]                  push_count;

   assign push_count  = {1'b0, push.first} + {1'b0, push.second};
   assign wr_ptr_next = wr_ptr_ff + JOBQ_PTR_WIDTH'(1);
   assign wr_ptr_in   = wr_ptr_ff + JOBQ_PTR_WIDTH'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + JOBQ_PTR_WIDTH'(pop);
   assign count_in    = count_ff + JOBQ_COUNT_WIDTH'(push_count) - JOBQ_COUNT_WIDTH'(pop);

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign room       = (count_ff <= JOBQ_COUNT_WIDTH'(JOBQ_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= job_first;
      end
      if (push.second) begin
         entry_ff[wr_ptr_next] <= job_second;
      end
   end

endmodule
`default_nettype wire

// File: sv/bru_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bru_back
// Six stage rate pipeline with a credit guarded result queue.
// ----------------------------------------------------------------------------
module bru_back
   import bru_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  job_type   job,
   input  logic      job_valid,
   output logic      job_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output value_type rsp_rate_x,
   output value_type rsp_rate_y,
   output logic      rsp_line_end
);

   localparam int PIPE_STAGES = 6;

   typedef struct packed {
      value_type sum_x;
      value_type twice_x;
      value_type sum_y;
      value_type twice_y;
      value_type b_plus_one;
      value_type center_x;
      value_type center_y;
      logic      line_end;
   } stage1_type;

   typedef struct packed {
      value_type   lap_x;
      value_type   lap_y;
      product_type xx_p;
      product_type b1x_p;
      product_type bx_p;
      value_type   center_y;
      logic        line_end;
   } stage2_type;

   typedef struct packed {
      value_type   xx;
      value_type   b1x;
      value_type   bx;
      product_type dx_p;
      product_type dy_p;
      value_type   center_y;
      logic        line_end;
   } stage3_type;

   typedef struct packed {
      product_type x2y_p;
      value_type   dx;
      value_type   dy;
      value_type   react_x0;
      value_type   bx;
      logic        line_end;
   } stage4_type;

   typedef struct packed {
      value_type x2y;
      value_type dx;
      value_type dy;
      value_type react_x0;
      value_type bx;
      logic      line_end;
   } stage5_type;

   typedef struct packed {
      value_type react_x;
      value_type react_y;
      value_type dx;
      value_type dy;
      logic      line_end;
   } stage6_type;

   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;
   stage3_type s3_ff, s3_in;
   stage4_type s4_ff, s4_in;
   stage5_type s5_ff, s5_in;
   stage6_type s6_ff, s6_in;

   logic [PIPE_STAGES-1:0]      vld_ff, vld_in;
   logic [OUTQ_COUNT_WIDTH-1:0] credit_ff, credit_in;
   logic                        issue, take;

   result_type                  outq_ff [OUTQ_DEPTH];
   result_type                  outq_wdata;
   logic [OUTQ_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                        outq_push;

   // a credit covers every job in flight plus every stored result
   assign issue     = job_valid && (credit_ff < OUTQ_COUNT_WIDTH'(OUTQ_DEPTH));
   assign job_pop   = issue;
   assign take      = rsp_pop && !rsp_empty;
   assign credit_in = credit_ff + OUTQ_COUNT_WIDTH'(issue) - OUTQ_COUNT_WIDTH'(take);
   assign vld_in    = {vld_ff[PIPE_STAGES-2:0], issue};

   always_comb begin
      s1_in.sum_x      = sat_add(job.left_x, job.right_x);
      s1_in.twice_x    = sat_add(job.center_x, job.center_x);
      s1_in.sum_y      = sat_add(job.left_y, job.right_y);
      s1_in.twice_y    = sat_add(job.center_y, job.center_y);
      s1_in.b_plus_one = sat_add(cfg.feed_b, UNIT_VALUE);
      s1_in.center_x   = job.center_x;
      s1_in.center_y   = job.center_y;
      s1_in.line_end   = job.line_end;
   end

   always_comb begin
      s2_in.lap_x    = sat_sub(s1_ff.sum_x, s1_ff.twice_x);
      s2_in.lap_y    = sat_sub(s1_ff.sum_y, s1_ff.twice_y);
      s2_in.xx_p     = mul_full(s1_ff.center_x, s1_ff.center_x);
      s2_in.b1x_p    = mul_full(s1_ff.b_plus_one, s1_ff.center_x);
      s2_in.bx_p     = mul_full(cfg.feed_b, s1_ff.center_x);
      s2_in.center_y = s1_ff.center_y;
      s2_in.line_end = s1_ff.line_end;
   end

   always_comb begin
      s3_in.xx       = sat_prod(s2_ff.xx_p);
      s3_in.b1x      = sat_prod(s2_ff.b1x_p);
      s3_in.bx       = sat_prod(s2_ff.bx_p);
      s3_in.dx_p     = mul_full(cfg.diffusion_x, s2_ff.lap_x);
      s3_in.dy_p     = mul_full(cfg.diffusion_y, s2_ff.lap_y);
      s3_in.center_y = s2_ff.center_y;
      s3_in.line_end = s2_ff.line_end;
   end

   always_comb begin
      s4_in.x2y_p    = mul_full(s3_ff.xx, s3_ff.center_y);
      s4_in.dx       = sat_prod(s3_ff.dx_p);
      s4_in.dy       = sat_prod(s3_ff.dy_p);
      s4_in.react_x0 = sat_sub(cfg.feed_a, s3_ff.b1x);
      s4_in.bx       = s3_ff.bx;
      s4_in.line_end = s3_ff.line_end;
   end

   always_comb begin
      s5_in.x2y      = sat_prod(s4_ff.x2y_p);
      s5_in.dx       = s4_ff.dx;
      s5_in.dy       = s4_ff.dy;
      s5_in.react_x0 = s4_ff.react_x0;
      s5_in.bx       = s4_ff.bx;
      s5_in.line_end = s4_ff.line_end;
   end

   always_comb begin
      s6_in.react_x  = sat_add(s5_ff.react_x0, s5_ff.x2y);
      s6_in.react_y  = sat_sub(s5_ff.bx, s5_ff.x2y);
      s6_in.dx       = s5_ff.dx;
      s6_in.dy       = s5_ff.dy;
      s6_in.line_end = s5_ff.line_end;
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
      s6_ff <= s6_in;
   end

   // result queue, final sum lands on the write
   assign outq_push  = vld_ff[PIPE_STAGES-1];
   assign outq_wdata = '{rate_x: sat_add(s6_ff.dx, s6_ff.react_x),
                         rate_y: sat_add(s6_ff.dy, s6_ff.react_y),
                         line_end: s6_ff.line_end};
   assign wr_ptr_in  = wr_ptr_ff + OUTQ_PTR_WIDTH'(outq_push);
   assign rd_ptr_in  = rd_ptr_ff + OUTQ_PTR_WIDTH'(take);
   assign count_in   = count_ff + OUTQ_COUNT_WIDTH'(outq_push) - OUTQ_COUNT_WIDTH'(take);

   always_ff @(posedge clock) begin
      if (outq_push) begin
         outq_ff[wr_ptr_ff] <= outq_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         credit_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         vld_ff    <= vld_in;
         credit_ff <= credit_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_empty    = (count_ff == '0);
   assign rsp_rate_x   = outq_ff[rd_ptr_ff].rate_x;
   assign rsp_rate_y   = outq_ff[rd_ptr_ff].rate_y;
   assign rsp_line_end = outq_ff[rd_ptr_ff].line_end;

endmodule
`default_nettype wire

// File: sv/bru_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bru_checker
// Port level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "brusselator_1d_rate_stencil_assert.svh"

module bru_checker
   import bru_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_push,
   input logic      req_full,
   input logic      req_final_point,
   input logic      rsp_empty,
   input logic      rsp_pop,
   input value_type rsp_rate_x,
   input value_type rsp_rate_y,
   input logic      rsp_line_end
);

   // final points taken whose line end result has not been popped yet
   logic [7:0] open_lines_ff, open_lines_in;
   logic       final_taken, end_popped;

   assign final_taken   = req_push && !req_full && req_final_point;
   assign end_popped    = rsp_pop && !rsp_empty && rsp_line_end;
   assign open_lines_in = open_lines_ff + 8'(final_taken) - 8'(end_popped);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_lines_ff <= '0;
      end else begin
         open_lines_ff <= open_lines_in;
      end
   end

   `BRU_ASSERT_AFTER_RESET(a_reset_clean, rsp_empty && !req_full, "queues not empty after reset")

   `BRU_ASSERT_NOW(a_line_end_owed, end_popped, open_lines_ff != '0, "line end without a final point")

   `BRU_ASSERT_NEXT(a_rsp_held, !rsp_empty && !rsp_pop, !rsp_empty, "waiting result vanished")

   `BRU_ASSERT_NEXT(a_rsp_stable, !rsp_empty && !rsp_pop, $stable(rsp_rate_x) && $stable(rsp_rate_y) && $stable(rsp_line_end), "waiting result changed")

endmodule

bind brusselator_1d_rate_stencil bru_checker u_checker (.*);
`default_nettype wire

// File: verif/brusselator_1d_rate_stencil_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brusselator_1d_rate_stencil_tb
// Self-checking bench for the 1-D Brusselator rate stencil. Mesh lines are
// pushed through the request queue while a bit-accurate mirror of the window
// and the saturating Q16.16 arithmetic predicts every rate pair; the popped
// results are compared in order against those predictions.
// ----------------------------------------------------------------------------
module brusselator_1d_rate_stencil_tb
   import bru_pkg::*;
;

   localparam int GENTLE_SPAN  = 1 << 18;      // +/- 4.0 in Q16.16
   localparam int WIDE_SPAN    = 1 << 24;      // +/- 256.0
   localparam int DRAIN_CYCLES = 24;           // extra wait after all predictions drain
   localparam int RUN_LIMIT_NS = 1_000_000;    // run time limit, far past any sane run
   localparam int RSP_HOLD     = 300;          // long receiver stall, in cycles
   // first register index past the map; writes there must be dropped
   localparam csr_index_type CSR_FIRST_UNUSED = csr_index_type'(CSR_DIFFUSION_Y + 1);
   localparam csr_index_type CSR_LAST_INDEX   = '1;

   logic          clock;
   logic          reset;
   logic          req_push;
   logic          req_full;
   value_type     req_x_value;
   value_type     req_y_value;
   logic          req_final_point;
   logic          rsp_empty;
   logic          rsp_pop;
   value_type     rsp_rate_x;
   value_type     rsp_rate_y;
   logic          rsp_line_end;
   logic          csr_wr_en;
   csr_index_type csr_index;
   value_type     csr_wdata;

   brusselator_1d_rate_stencil dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .req_final_point (req_final_point),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_rate_x      (rsp_rate_x),
      .rsp_rate_y      (rsp_rate_y),
      .rsp_line_end    (rsp_line_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Mirror of the block: register file, stencil window, expected rates
   // ------------------------------------------------------------------------
   cfg_type          mirror_cfg   = '0;
   window_state_type window_state = WIN_EMPTY;
   value_type        left_x       = '0;   // left neighbor of the held point
   value_type        left_y       = '0;
   value_type        mid_x        = '0;   // held point, waiting for its right side
   value_type        mid_y        = '0;

   result_type pending_rates[$];           // predicted rate pairs, oldest first
   int         mismatches    = 0;
   int         send_idle_pct = 0;          // chance per cycle the sender holds off
   int         recv_idle_pct = 0;          // chance per cycle the receiver holds off
   int         rsp_hold_len  = 0;          // request for one long receiver stall

   // saturate a wide intermediate back to the value range
   function automatic value_type clamp_q(longint v);
      if (v > longint'(VALUE_MAX)) return VALUE_MAX;
      if (v < longint'(VALUE_MIN)) return VALUE_MIN;
      return value_type'(v);
   endfunction

   function automatic value_type add_q(value_type a, value_type b);
      return clamp_q(longint'(a) + longint'(b));
   endfunction

   function automatic value_type sub_q(value_type a, value_type b);
      return clamp_q(longint'(a) - longint'(b));
   endfunction

   // exact 64-bit product, arithmetic shift = floor, then clamp
   function automatic value_type mul_q(value_type a, value_type b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return clamp_q(prod >>> FRACTION_BITS);
   endfunction

   // time derivatives of one mesh point given its two neighbors
   function automatic result_type point_rates(value_type lx, value_type ly,
                                              value_type cx, value_type cy,
                                              value_type rx, value_type ry,
                                              logic last);
      value_type  lap_x, lap_y, xxy, react_x, react_y;
      result_type r;
      lap_x   = sub_q(add_q(lx, rx), add_q(cx, cx));
      lap_y   = sub_q(add_q(ly, ry), add_q(cy, cy));
      xxy     = mul_q(mul_q(cx, cx), cy);
      react_x = add_q(sub_q(mirror_cfg.feed_a,
                            mul_q(add_q(mirror_cfg.feed_b, UNIT_VALUE), cx)), xxy);
      react_y = sub_q(mul_q(mirror_cfg.feed_b, cx), xxy);
      r.rate_x   = add_q(mul_q(mirror_cfg.diffusion_x, lap_x), react_x);
      r.rate_y   = add_q(mul_q(mirror_cfg.diffusion_y, lap_y), react_y);
      r.line_end = last;
      return r;
   endfunction

   // advance the window by one accepted point and queue what it releases
   function automatic void absorb_point(value_type x, value_type y, logic fin);
      if (window_state == WIN_EMPTY) begin
         if (fin) begin
            // one point line: boundary on both sides, window stays empty
            pending_rates.push_back(point_rates(mirror_cfg.feed_a, mirror_cfg.boundary_y,
                                                x, y, mirror_cfg.feed_a,
                                                mirror_cfg.boundary_y, 1'b1));
         end else begin
            // line start: left boundary latched now, later writes do not move it
            left_x       = mirror_cfg.feed_a;
            left_y       = mirror_cfg.boundary_y;
            mid_x        = x;
            mid_y        = y;
            window_state = WIN_HOLDING;
         end
         return;
      end
      pending_rates.push_back(point_rates(left_x, left_y, mid_x, mid_y, x, y, 1'b0));
      left_x = mid_x;
      left_y = mid_y;
      mid_x  = x;
      mid_y  = y;
      if (fin) begin
         pending_rates.push_back(point_rates(left_x, left_y, mid_x, mid_y,
                                             mirror_cfg.feed_a, mirror_cfg.boundary_y,
                                             1'b1));
         window_state = WIN_EMPTY;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock, run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: pops at random, honors a requested long stall, and
   // scores every popped transaction against the oldest prediction.
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int         hold_left;
      result_type want;
      hold_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_rates.size() == 0) begin
               mismatches++;
               $display("%0t unexpected result: expected none, actual rate_x %0d rate_y %0d line_end %0b",
                        $time, rsp_rate_x, rsp_rate_y, rsp_line_end);
            end else begin
               want = pending_rates.pop_front();
               if (rsp_rate_x !== want.rate_x) begin
                  mismatches++;
                  $display("%0t rate_x mismatch: expected %0d actual %0d",
                           $time, want.rate_x, rsp_rate_x);
               end
               if (rsp_rate_y !== want.rate_y) begin
                  mismatches++;
                  $display("%0t rate_y mismatch: expected %0d actual %0d",
                           $time, want.rate_y, rsp_rate_y);
               end
               if (rsp_line_end !== want.line_end) begin
                  mismatches++;
                  $display("%0t line_end mismatch: expected %0b actual %0b",
                           $time, want.line_end, rsp_line_end);
               end
            end
         end
         // a stall request is picked up here and counted down locally
         if (rsp_hold_len != 0) begin
            hold_left    = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side and register port
   // ------------------------------------------------------------------------

   // push one mesh point; req_push is left high so back-to-back
   // transactions never see it drop and rise in the same step
   task automatic send_point(value_type x, value_type y, logic fin);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push        <= 1'b1;
      req_x_value     <= x;
      req_y_value     <= y;
      req_final_point <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      absorb_point(x, y, fin);
   endtask

   // one register write; the caller lowers csr_wr_en afterwards
   task automatic csr_cycle(csr_index_type idx, value_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_FEED_A:      mirror_cfg.feed_a      = data;
         CSR_FEED_B:      mirror_cfg.feed_b      = data;
         CSR_BOUNDARY_Y:  mirror_cfg.boundary_y  = data;
         CSR_DIFFUSION_X: mirror_cfg.diffusion_x = data;
         CSR_DIFFUSION_Y: mirror_cfg.diffusion_y = data;
         default: ;       // unmapped index, dropped by the block
      endcase
   endtask

   // write all five constants back to back, optionally followed by junk
   // writes to unmapped indexes
   task automatic program_constants(cfg_type c, bit add_stray);
      csr_cycle(CSR_FEED_A,      c.feed_a);
      csr_cycle(CSR_FEED_B,      c.feed_b);
      csr_cycle(CSR_BOUNDARY_Y,  c.boundary_y);
      csr_cycle(CSR_DIFFUSION_X, c.diffusion_x);
      csr_cycle(CSR_DIFFUSION_Y, c.diffusion_y);
      if (add_stray) begin
         csr_cycle(CSR_FIRST_UNUSED, value_type'($urandom()));
         csr_cycle(CSR_LAST_INDEX,   value_type'($urandom()));
         csr_cycle(csr_index_type'($urandom_range(CSR_LAST_INDEX, CSR_FIRST_UNUSED)),
                   value_type'($urandom()));
      end
      csr_wr_en <= 1'b0;
   endtask

   // stop pushing, let every prediction drain, then allow for a point that
   // is still in flight without producing a result
   task automatic settle();
      req_push <= 1'b0;
      while (pending_rates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly moderate values, some wide, some raw bit patterns, some corners
   function automatic value_type random_q();
      case ($urandom_range(9))
         0, 1, 2, 3, 4:
            return value_type'(int'($urandom_range(2 * GENTLE_SPAN)) - GENTLE_SPAN);
         5, 6:
            return value_type'(int'($urandom_range(2 * WIDE_SPAN)) - WIDE_SPAN);
         7, 8:
            return value_type'($urandom());
         default:
            case ($urandom_range(6))
               0: return VALUE_MAX;
               1: return VALUE_MIN;
               2: return '0;
               3: return value_type'(1);
               4: return value_type'(-1);
               5: return UNIT_VALUE;
               default: return -UNIT_VALUE;
            endcase
      endcase
   endfunction

   function automatic cfg_type random_constants(bit gentle);
      cfg_type c;
      if (gentle) begin
         c.feed_a      = value_type'($urandom_range(GENTLE_SPAN, 1));
         c.feed_b      = value_type'($urandom_range(GENTLE_SPAN));
         c.boundary_y  = value_type'($urandom_range(GENTLE_SPAN));
         c.diffusion_x = value_type'($urandom_range(GENTLE_SPAN));
         c.diffusion_y = value_type'($urandom_range(GENTLE_SPAN));
      end else begin
         c.feed_a      = random_q();
         c.feed_b      = random_q();
         c.boundary_y  = random_q();
         c.diffusion_x = random_q();
         c.diffusion_y = random_q();
      end
      return c;
   endfunction

   // whole lines of random length with random content; the last line may
   // be cut short, leaving a point held in the window across the phase
   task automatic send_lines(int count);
      int sent, len, k;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         for (k = 0; k < len && sent < count; k++) begin
            send_point(random_q(), random_q(), k == len - 1);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // registers at their reset value of zero
   task automatic test_reset_constants();
      send_point(UNIT_VALUE, UNIT_VALUE, 1'b0);
      send_point(value_type'(32'sh0002_0000), -UNIT_VALUE, 1'b0);
      send_point(value_type'(32'sh0000_8000), value_type'(32'sh0003_0000), 1'b1);
      settle();
   endtask

   // textbook parameters a=1, b=3, a line of five points
   task automatic test_typical_line();
      cfg_type c;
      c = '{feed_a: 32'sh0001_0000, feed_b: 32'sh0003_0000, boundary_y: 32'sh0003_0000,
            diffusion_x: 32'sh0000_4000, diffusion_y: 32'sh0000_2000};
      program_constants(c, 1'b0);
      send_point(value_type'(32'sh0001_0000), value_type'(32'sh0003_0000), 1'b0);
      send_point(value_type'(32'sh0001_4000), value_type'(32'sh0002_c000), 1'b0);
      send_point(value_type'(32'sh0000_c000), value_type'(32'sh0003_8000), 1'b0);
      send_point(value_type'(32'sh0001_8000), value_type'(32'sh0002_0000), 1'b0);
      send_point(value_type'(32'sh0000_8000), value_type'(32'sh0003_4000), 1'b1);
      settle();
   endtask

   // one point line, then the shortest regular mesh
   task automatic test_short_lines();
      send_point(value_type'(32'sh0002_0000), value_type'(32'sh0001_0000), 1'b1);
      send_point(value_type'(32'sh0000_4000), value_type'(32'sh0004_0000), 1'b0);
      send_point(-UNIT_VALUE, value_type'(32'sh0000_1000), 1'b1);
      settle();
   endtask

   // junk at unmapped indexes must leave the five constants untouched
   task automatic test_unmapped_index();
      program_constants(random_constants(1'b1), 1'b1);
      send_point(random_q(), random_q(), 1'b0);
      send_point(random_q(), random_q(), 1'b1);
      settle();
   endtask

   // every constant at the rails and the values at the rails or zero, to drive saturation
   task automatic test_extremes();
      program_constants('{VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX, VALUE_MAX}, 1'b0);
      send_point(VALUE_MAX, VALUE_MIN, 1'b0);
      send_point(VALUE_MIN, VALUE_MAX, 1'b0);
      send_point('0, VALUE_MAX, 1'b1);
      settle();
      program_constants('{VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN, VALUE_MIN}, 1'b0);
      send_point(VALUE_MIN, VALUE_MIN, 1'b0);
      send_point(VALUE_MAX, VALUE_MAX, 1'b1);
      send_point(VALUE_MAX, VALUE_MIN, 1'b1);
      settle();
   endtask

   // new constants between the first point and the rest of a line: the
   // latched left boundary keeps the old values, everything else switches
   task automatic test_config_mid_line();
      program_constants(random_constants(1'b1), 1'b0);
      send_point(random_q(), random_q(), 1'b0);
      settle();
      program_constants(random_constants(1'b1), 1'b0);
      send_point(random_q(), random_q(), 1'b0);
      send_point(random_q(), random_q(), 1'b1);
      settle();
   endtask

   // receiver stalls long while the sender keeps pushing, so the result
   // and job queues fill and req_full has to hold the sender off
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_constants(random_constants(1'b1), 1'b0);
      rsp_hold_len = RSP_HOLD;
      send_lines(60);
      settle();
   endtask

   task automatic test_random_phase(int sender_pct, int receiver_pct, bit gentle, int count);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      program_constants(random_constants(gentle), 1'b0);
      send_lines(count / 2);
      settle();
      program_constants(random_constants(!gentle), 1'b1);
      send_lines(count - count / 2);
      settle();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_push        <= 1'b0;
      req_x_value     <= '0;
      req_y_value     <= '0;
      req_final_point <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_FEED_A;
      csr_wdata       <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      recv_idle_pct = 72;
      test_reset_constants();
      test_typical_line();
      test_short_lines();
      test_unmapped_index();
      test_extremes();
      test_config_mid_line();
      test_backpressure();

      test_random_phase(27, 72, 1'b1, 170);
      test_random_phase(72, 27, 1'b0, 170);
      test_random_phase(0, 0, 1'b1, 160);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: brusselator_1d_rate_stencil.f
+incdir+sv
sv/bru_pkg.sv
sv/bru_csr.sv
sv/bru_front.sv
sv/bru_job_queue.sv
sv/bru_back.sv
sv/brusselator_1d_rate_stencil.sv
sv/bru_checker.sv
verif/brusselator_1d_rate_stencil_tb.sv
